// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/pnp_pkg.sv =====
// Shared constants, register indexes and types of the polyline nearest point core.
// Depends on nothing.
`timescale 1ns / 1ps
package pnp_pkg;
   localparam int COORD_BITS    = 24;
   localparam int FRAC_BITS     = 24;
   localparam int IDX_BITS      = 16;
   localparam int MAX_VERTICES  = 65536;
   localparam int DIST_BITS     = 50;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SEARCH_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEARCH_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEARCH_Z   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PLANAR     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_IDX  = 3'd4;

   localparam logic [IDX_BITS-1:0] CNT_MAX = IDX_BITS'(MAX_VERTICES - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type             search_x;
      coord_type             search_y;
      coord_type             search_z;
      logic                  planar;
      logic [IDX_BITS-1:0]   first_index;
   } cfg_type;

   typedef struct packed {
      coord_type [2:0]       a;
      coord_type [2:0]       b;
      coord_type [2:0]       p;
      logic                  visit;
      logic                  last;
      logic [IDX_BITS-1:0]   seg_index;
   } seg_type;
endpackage

// ===== hw/rtl/pnp_if.sv =====
// Valid/ready channels for vertices and results.
// Depends on pnp_pkg.
`timescale 1ns / 1ps
interface pnp_req_if;
   logic                      valid;
   logic                      ready;
   logic signed [pnp_pkg::COORD_BITS-1:0] vertex_x;
   logic signed [pnp_pkg::COORD_BITS-1:0] vertex_y;
   logic signed [pnp_pkg::COORD_BITS-1:0] vertex_z;
   logic                      last_vertex;
   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface pnp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      found;
   logic [pnp_pkg::IDX_BITS-1:0] segment_index;
   logic signed [pnp_pkg::COORD_BITS-1:0] nearest_x;
   logic signed [pnp_pkg::COORD_BITS-1:0] nearest_y;
   logic signed [pnp_pkg::COORD_BITS-1:0] nearest_z;
   logic [pnp_pkg::DIST_BITS-1:0] distance_squared;
   modport source (output valid, found, segment_index, nearest_x, nearest_y, nearest_z,
                   distance_squared, input ready);
   modport sink (input valid, found, segment_index, nearest_x, nearest_y, nearest_z,
                 distance_squared, output ready);
endinterface

// ===== hw/rtl/pnp_front.sv =====
// Front end: accepts vertices, pairs them into segments and numbers them.
// Depends on pnp_pkg.
`timescale 1ns / 1ps
module pnp_front (
   input  logic             clock,
   input  logic             reset,
   input  pnp_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  pnp_pkg::coord_type vx,
   input  pnp_pkg::coord_type vy,
   input  pnp_pkg::coord_type vz,
   input  logic             vlast,
   input  logic             q_full,
   output logic             push,
   output pnp_pkg::seg_type seg
);
   pnp_pkg::coord_type [2:0] prev_ff, prev_in;
   logic have_prev_ff, have_prev_in;
   logic [pnp_pkg::IDX_BITS-1:0] cnt_ff, cnt_in;
   logic [pnp_pkg::IDX_BITS:0] idx_sum;

   assign in_ready = !q_full;
   assign push     = in_valid && in_ready;
   assign idx_sum  = {1'b0, cfg.first_index} + {1'b0, cnt_ff} - 1'b1;

   always_comb begin
      seg.a[0] = prev_ff[0];
      seg.a[1] = prev_ff[1];
      seg.a[2] = cfg.planar ? '0 : prev_ff[2];
      seg.b[0] = vx;
      seg.b[1] = vy;
      seg.b[2] = cfg.planar ? '0 : vz;
      seg.p[0] = cfg.search_x;
      seg.p[1] = cfg.search_y;
      seg.p[2] = cfg.planar ? '0 : cfg.search_z;
      seg.visit = have_prev_ff;
      seg.last  = vlast;
      seg.seg_index = idx_sum[pnp_pkg::IDX_BITS] ? '1 : idx_sum[pnp_pkg::IDX_BITS-1:0];
      prev_in = prev_ff;
      have_prev_in = have_prev_ff;
      cnt_in = cnt_ff;
      if (push) begin
         if (vlast) begin
            prev_in = '0;
            have_prev_in = 1'b0;
            cnt_in = '0;
         end else begin
            prev_in = {vz, vy, vx};
            have_prev_in = 1'b1;
            if (cnt_ff != pnp_pkg::CNT_MAX) cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         have_prev_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         have_prev_ff <= have_prev_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hw/rtl/pnp_queue.sv =====
// Short segment queue between front and back ends.
// Depends on pnp_pkg.
`timescale 1ns / 1ps
module pnp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pnp_pkg::seg_type wr_seg,
   input  logic             pop,
   output pnp_pkg::seg_type rd_seg,
   output logic             full,
   output logic             not_empty
);
   localparam int PW = $clog2(pnp_pkg::QUEUE_DEPTH);
   pnp_pkg::seg_type mem_ff [pnp_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == (PW+1)'(pnp_pkg::QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign rd_seg    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PW'((wr_ff + 1'b1) % pnp_pkg::QUEUE_DEPTH) : wr_ff;
      rd_in  = pop ? PW'((rd_ff + 1'b1) % pnp_pkg::QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wr_seg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hw/rtl/pnp_back.sv =====
// Back end: projects each segment, divides serially, keeps the best and emits results.
// Depends on pnp_pkg.
`timescale 1ns / 1ps
module pnp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  pnp_pkg::seg_type q_seg,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_found,
   output logic [pnp_pkg::IDX_BITS-1:0] out_index,
   output pnp_pkg::coord_type out_x,
   output pnp_pkg::coord_type out_y,
   output pnp_pkg::coord_type out_z,
   output logic [pnp_pkg::DIST_BITS-1:0] out_dist
);
   localparam int CW   = pnp_pkg::COORD_BITS;
   localparam int F    = pnp_pkg::FRAC_BITS;
   localparam int DW   = CW + 1;
   localparam int NW   = 2 * DW + 2;
   localparam int RW   = NW + 1;
   localparam int TW   = F + 1;
   localparam int PRW  = DW + TW;
   localparam int OW   = DW + 1;
   localparam int EW   = OW + 2;
   localparam int SW   = 2 * EW + 2;
   localparam int STW  = $clog2(F + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DIFF  = 10'b0000000010,
      S_DOT   = 10'b0000000100,
      S_CLASS = 10'b0000001000,
      S_DIV   = 10'b0000010000,
      S_MUL   = 10'b0000100000,
      S_OFF   = 10'b0001000000,
      S_SQR   = 10'b0010000000,
      S_CMP   = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   pnp_pkg::seg_type ent_ff, ent_in;
   logic signed [DW-1:0] d_ff [3], d_in [3], w_ff [3], w_in [3];
   logic signed [NW-1:0] num_ff, num_in;
   logic [NW-1:0] mag_ff, mag_in;
   logic [1:0] ax_ff, ax_in;
   logic [TW-1:0] t_ff, t_in;
   logic [RW-1:0] rem_ff, rem_in, shifted;
   logic [STW-1:0] step_ff, step_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic signed [EW-1:0] e_ff, e_in;
   logic [SW-1:0] dist_ff, dist_in;
   pnp_pkg::coord_type q_ff [3], q_in [3];
   logic [pnp_pkg::DIST_BITS-1:0] bdist_ff, bdist_in;
   logic [pnp_pkg::IDX_BITS-1:0] bseg_ff, bseg_in;
   pnp_pkg::coord_type bpt_ff [3], bpt_in [3];
   logic bvalid_ff, bvalid_in;
   logic ov_ff, ov_in, of_ff, of_in;
   logic [pnp_pkg::IDX_BITS-1:0] oi_ff, oi_in;
   pnp_pkg::coord_type op_ff [3], op_in [3];
   logic [pnp_pkg::DIST_BITS-1:0] od_ff, od_in;
   logic signed [DW-1:0] dcur;
   logic [DW-1:0] dabs;
   logic [PRW:0] ceil_sum;
   logic [OW-1:0] omag;
   logic signed [OW-1:0] off;
   logic signed [OW:0] qv;
   logic signed [2*DW-1:0] wd_prod, dd_prod;
   logic signed [2*EW-1:0] ee_prod;

   assign out_valid = ov_ff;
   assign out_found = of_ff;
   assign out_index = oi_ff;
   assign out_x     = op_ff[0];
   assign out_y     = op_ff[1];
   assign out_z     = op_ff[2];
   assign out_dist  = od_ff;

   always_comb begin
      state_in = state_ff; ent_in = ent_ff; d_in = d_ff; w_in = w_ff;
      num_in = num_ff; mag_in = mag_ff; ax_in = ax_ff; t_in = t_ff;
      rem_in = rem_ff; step_in = step_ff; prod_in = prod_ff; e_in = e_ff;
      dist_in = dist_ff; q_in = q_ff; bdist_in = bdist_ff; bseg_in = bseg_ff;
      bpt_in = bpt_ff; bvalid_in = bvalid_ff; of_in = of_ff; oi_in = oi_ff;
      op_in = op_ff; od_in = od_ff;
      ov_in = ov_ff && !out_ready;
      pop = 1'b0;
      dcur = d_ff[ax_ff];
      dabs = dcur[DW-1] ? DW'(-dcur) : DW'(dcur);
      wd_prod = w_ff[ax_ff] * d_ff[ax_ff];
      dd_prod = d_ff[ax_ff] * d_ff[ax_ff];
      ee_prod = e_ff * e_ff;
      shifted = (step_ff == '0) ? rem_ff : {rem_ff[RW-2:0], 1'b0};
      ceil_sum = {1'b0, prod_ff} + (PRW+1)'((1 << F) - 1);
      omag = dcur[DW-1] ? OW'(ceil_sum >> F) : OW'(prod_ff >> F);
      off = dcur[DW-1] ? -$signed(omag) : $signed(omag);
      qv = (OW+1)'(ent_ff.a[ax_ff]) + (OW+1)'(off);
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               ent_in = q_seg;
               state_in = q_seg.visit ? S_DIFF : S_FIN;
            end
         end
         S_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               d_in[i] = DW'(ent_ff.b[i]) - DW'(ent_ff.a[i]);
               w_in[i] = DW'(ent_ff.p[i]) - DW'(ent_ff.a[i]);
            end
            num_in = '0; mag_in = '0; ax_in = '0;
            state_in = S_DOT;
         end
         S_DOT: begin
            num_in = num_ff + NW'(wd_prod);
            mag_in = mag_ff + NW'($unsigned(dd_prod));
            ax_in = ax_ff + 1'b1;
            if (ax_ff == 2'd2) state_in = S_CLASS;
         end
         S_CLASS: begin
            ax_in = '0; dist_in = '0;
            if (mag_ff == '0) begin
               state_in = S_FIN;
            end else if (num_ff < 0) begin
               t_in = '0; state_in = S_MUL;
            end else if (num_ff > $signed(mag_ff)) begin
               t_in = TW'(1) << F; state_in = S_MUL;
            end else begin
               t_in = '0; rem_in = RW'($unsigned(num_ff)); step_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            t_in = (step_ff == '0) ? t_ff : {t_ff[TW-2:0], 1'b0};
            rem_in = shifted;
            if (shifted >= {1'b0, mag_ff}) begin
               rem_in = shifted - {1'b0, mag_ff};
               t_in[0] = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STW'(F)) state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = PRW'(dabs * t_ff);
            state_in = S_OFF;
         end
         S_OFF: begin
            q_in[ax_ff] = CW'(qv);
            e_in = EW'(ent_ff.p[ax_ff]) - EW'(qv);
            state_in = S_SQR;
         end
         S_SQR: begin
            dist_in = dist_ff + SW'($unsigned(ee_prod));
            ax_in = ax_ff + 1'b1;
            state_in = (ax_ff == 2'd2) ? S_CMP : S_MUL;
         end
         S_CMP: begin
            if (dist_ff < SW'(bdist_ff)) begin
               bdist_in = pnp_pkg::DIST_BITS'(dist_ff);
               bpt_in = q_ff;
               bseg_in = ent_ff.seg_index;
               bvalid_in = 1'b1;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!ent_ff.last) begin
               state_in = S_IDLE;
            end else if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               of_in = bvalid_ff;
               oi_in = bvalid_ff ? bseg_ff : '0;
               for (int i = 0; i < 3; i++) op_in[i] = bvalid_ff ? bpt_ff[i] : '0;
               od_in = bvalid_ff ? bdist_ff : '0;
               bdist_in = '1; bseg_in = '0; bvalid_in = 1'b0;
               for (int i = 0; i < 3; i++) bpt_in[i] = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in; d_ff <= d_in; w_ff <= w_in; num_ff <= num_in;
      mag_ff <= mag_in; t_ff <= t_in; rem_ff <= rem_in; step_ff <= step_in;
      prod_ff <= prod_in; e_ff <= e_in; dist_ff <= dist_in; q_ff <= q_in;
      of_ff <= of_in; oi_ff <= oi_in; op_ff <= op_in; od_ff <= od_in;
      ax_ff <= ax_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bdist_ff <= '1;
         bseg_ff <= '0;
         bpt_ff <= '{default: '0};
         bvalid_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bdist_ff <= bdist_in;
         bseg_ff <= bseg_in;
         bpt_ff <= bpt_in;
         bvalid_ff <= bvalid_in;
         ov_ff <= ov_in;
      end
   end
endmodule

// ===== hw/rtl/polyline_nearest_point_core.sv =====
// Top level of the polyline nearest point core: registers, front, queue, back.
// Depends on pnp_pkg, pnp_if, pnp_front, pnp_queue, pnp_back, assert_macros.svh.
// A vertex whose segment projects inside passes through the dot products over the
// three axes, serial division and, per axis, offset and squared error in the back
// end. A point clamped to a segment end skips the division; a zero-length segment
// and a first vertex skip the projection; a last vertex also waits until the result register is
// free. A two-entry queue lets the front take vertices while the back works.
// Write the search registers only while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polyline_nearest_point_core (
   input  logic clock,
   input  logic reset,
   pnp_req_if.sink   req_if,
   pnp_rsp_if.source rsp_if,
   input  logic csr_we,
   input  logic [pnp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pnp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   pnp_pkg::cfg_type cfg_ff, cfg_in;
   pnp_pkg::seg_type seg_w, seg_r;
   logic push, pop, q_full, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pnp_pkg::CSR_SEARCH_X:  cfg_in.search_x = csr_wdata[pnp_pkg::COORD_BITS-1:0];
            pnp_pkg::CSR_SEARCH_Y:  cfg_in.search_y = csr_wdata[pnp_pkg::COORD_BITS-1:0];
            pnp_pkg::CSR_SEARCH_Z:  cfg_in.search_z = csr_wdata[pnp_pkg::COORD_BITS-1:0];
            pnp_pkg::CSR_PLANAR:    cfg_in.planar = csr_wdata[0];
            pnp_pkg::CSR_FIRST_IDX: cfg_in.first_index = csr_wdata[pnp_pkg::IDX_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   pnp_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_if.valid), .in_ready(req_if.ready),
      .vx(req_if.vertex_x), .vy(req_if.vertex_y), .vz(req_if.vertex_z),
      .vlast(req_if.last_vertex), .q_full(q_full), .push(push), .seg(seg_w)
   );

   pnp_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .wr_seg(seg_w), .pop(pop),
      .rd_seg(seg_r), .full(q_full), .not_empty(q_valid)
   );

   pnp_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_seg(seg_r), .pop(pop),
      .out_valid(rsp_if.valid), .out_ready(rsp_if.ready), .out_found(rsp_if.found),
      .out_index(rsp_if.segment_index), .out_x(rsp_if.nearest_x),
      .out_y(rsp_if.nearest_y), .out_z(rsp_if.nearest_z),
      .out_dist(rsp_if.distance_squared)
   );

   `ASSERT_IMPLIES(a_empty_zero, clock, reset, rsp_if.valid && !rsp_if.found, rsp_if.distance_squared == '0 && rsp_if.segment_index == '0)
   `ASSERT_IMPLIES(a_dist_bound, clock, reset, rsp_if.valid && rsp_if.found, rsp_if.distance_squared < 50'h3000000000000)
   `ASSERT_NEXT(a_push_pop, clock, reset, q_full && !pop, !push)
endmodule
